// ===== rtl/core/ils_pkg.sv =====
// Package: shared types, constants and state codes for interval latency statistics
package ils_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int SLOT_W = 4;
    localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [1:0] ST_BEGIN = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_NO_BEGIN = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] event_key;
        logic [63:0] timestamp;
    } t_in;

    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  status;
        logic [31:0] sample_count;
        logic [63:0] min_ticks;
        logic [63:0] max_ticks;
        logic [63:0] total_ticks;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic search;
        logic update;
    } t_cmd;

endpackage

// ===== rtl/core/ils_ctrl.sv =====
// Controller: sequences capture, key search and slot update
module ils_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output ils_pkg::t_cmd     o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    ils_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ils_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            ils_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = ils_pkg::S_MATCH;
                end
            end
            ils_pkg::S_MATCH: begin
                o_cmd.search = 1'b1;
                n_state = ils_pkg::S_UPDATE;
            end
            ils_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                o_done = 1'b1;
                n_state = ils_pkg::S_IDLE;
            end
            default: begin
                n_state = ils_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ils_dp.sv =====
// Datapath: key table, per-slot statistics and result register
module ils_dp #(
    parameter int SLOTS = ils_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ils_pkg::t_cmd     i_cmd,
    input  logic              i_done,
    input  ils_pkg::t_in      i_in,
    output ils_pkg::t_out     o_res,
    output logic              o_res_valid
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    ils_pkg::t_in r_in;
    logic [31:0] r_key [SLOTS];
    logic [63:0] r_start [SLOTS];
    logic [63:0] r_min [SLOTS];
    logic [63:0] r_max [SLOTS];
    logic [63:0] r_total [SLOTS];
    logic [31:0] r_count [SLOTS];
    logic [SLOTS-1:0] r_open;
    logic [CW-1:0] r_used;
    logic [IW-1:0] r_slot;
    logic r_full;
    ils_pkg::t_out r_res;
    logic r_res_valid;

    // parallel key compare against entries in use
    logic [SLOTS-1:0] hit;
    logic [IW-1:0] hit_idx;
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit[i] = (CW'(i) < r_used) && (r_key[i] == r_in.event_key);
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) hit_idx = IW'(i);
        end
    end

    logic [63:0] elapsed, sum;
    logic [63:0] st_start, st_min, st_max, st_total;
    logic [31:0] st_count;
    logic [64:0] sum_w;
    always_comb begin
        st_start = r_start[r_slot];
        st_min = r_min[r_slot];
        st_max = r_max[r_slot];
        st_total = r_total[r_slot];
        st_count = r_count[r_slot];
        elapsed = r_in.timestamp - st_start;
        sum_w = {1'b0, st_total} + {1'b0, elapsed};
        sum = sum_w[64] ? ils_pkg::ALL_ONES64 : sum_w[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_open <= '0;
            r_res_valid <= 1'b0;
            r_full <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_min[i] <= ils_pkg::ALL_ONES64;
                r_max[i] <= '0;
                r_total[i] <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_res_valid <= i_done;
            if (i_cmd.load) begin
                r_in <= i_in;
            end
            if (i_cmd.search) begin
                r_full <= ~(|hit) && (r_used == CW'(SLOTS));
                if (|hit) begin
                    r_slot <= hit_idx;
                end else if (r_used != CW'(SLOTS)) begin
                    r_slot <= r_used[IW-1:0];
                    r_key[r_used[IW-1:0]] <= r_in.event_key;
                    r_used <= r_used + CW'(1);
                end
            end
            if (i_cmd.update) begin
                r_res.slot <= r_full ? 4'd0 : 4'(r_slot);
                if (r_full) begin
                    r_res.status <= ils_pkg::ST_FULL;
                    r_res.sample_count <= '0;
                    r_res.min_ticks <= ils_pkg::ALL_ONES64;
                    r_res.max_ticks <= '0;
                    r_res.total_ticks <= '0;
                end else if (r_in.kind == ils_pkg::KIND_BEGIN) begin
                    r_start[r_slot] <= r_in.timestamp;
                    r_open[r_slot] <= 1'b1;
                    r_res.status <= ils_pkg::ST_BEGIN;
                    r_res.sample_count <= st_count;
                    r_res.min_ticks <= st_min;
                    r_res.max_ticks <= st_max;
                    r_res.total_ticks <= st_total;
                end else if (!r_open[r_slot]) begin
                    r_res.status <= ils_pkg::ST_NO_BEGIN;
                    r_res.sample_count <= st_count;
                    r_res.min_ticks <= st_min;
                    r_res.max_ticks <= st_max;
                    r_res.total_ticks <= st_total;
                end else begin
                    r_open[r_slot] <= 1'b0;
                    r_res.status <= ils_pkg::ST_END;
                    r_min[r_slot] <= (elapsed < st_min) ? elapsed : st_min;
                    r_max[r_slot] <= (elapsed > st_max) ? elapsed : st_max;
                    r_total[r_slot] <= sum;
                    r_res.min_ticks <= (elapsed < st_min) ? elapsed : st_min;
                    r_res.max_ticks <= (elapsed > st_max) ? elapsed : st_max;
                    r_res.total_ticks <= sum;
                    if (st_count != ils_pkg::ALL_ONES32) begin
                        r_count[r_slot] <= st_count + 32'd1;
                        r_res.sample_count <= st_count + 32'd1;
                    end else begin
                        r_res.sample_count <= st_count;
                    end
                end
            end
        end
    end

    assign o_res = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// ===== rtl/core/interval_latency_statistics.sv =====
// Top level: interval latency statistics, controller plus datapath
//
// channel   signals                      transfer when
// input     i_start, o_busy, i_item      i_start && !o_busy
// result    o_valid, o_result            o_valid (one cycle, no back-pressure)
//
// Each mark goes through capture, key search over all slots and slot update in turn.
// The result strobes in the cycle after the update; busy drops in that same cycle.
// Reset is synchronous and clears slot table fill and statistics at once.
// The receiver cannot stall; results are never held.
module interval_latency_statistics #(
    parameter int SLOTS = ils_pkg::SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ils_pkg::t_in    i_item,
    output logic            o_busy,
    output logic            o_valid,
    output ils_pkg::t_out   o_result
);

    ils_pkg::t_cmd cmd;
    logic done;

    ils_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (done)
    );

    ils_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_done      (done),
        .i_in        (i_item),
        .o_res       (o_result),
        .o_res_valid (o_valid)
    );

endmodule

// ===== tb/interval_latency_statistics_tb.sv =====
// Testbench: interval latency statistics, predicted slot stats checked per result
`timescale 1ns / 100ps

module interval_latency_statistics_tb;

    localparam int NSLOT = 16;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    ils_pkg::t_in   i_item = '0;
    logic           o_busy;
    logic           o_valid;
    ils_pkg::t_out  o_result;

    interval_latency_statistics dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] key_tab [NSLOT];
    int          keys_used;
    logic        open_flag [NSLOT];
    logic [63:0] open_ts [NSLOT];
    logic [63:0] min_t [NSLOT];
    logic [63:0] max_t [NSLOT];
    logic [63:0] sum_t [NSLOT];
    logic [31:0] cnt_t [NSLOT];

    ils_pkg::t_in  marks_q [$];
    ils_pkg::t_out stats_q [$];
    int   errors = 0;
    int   send_idle = 15;
    bit   stim_done = 0;
    logic [31:0] keys_pool [NSLOT];

    function automatic ils_pkg::t_out predict_stats(ils_pkg::t_in m);
        ils_pkg::t_out r;
        int s;
        logic [63:0] el;
        logic [64:0] acc;
        s = -1;
        for (int i = 0; i < keys_used; i++)
            if (s < 0 && key_tab[i] == m.event_key) s = i;
        if (s < 0 && keys_used < NSLOT) begin
            s = keys_used;
            key_tab[s] = m.event_key;
            keys_used++;
        end
        if (s < 0) begin
            r = '0;
            r.status = ils_pkg::ST_FULL;
            r.min_ticks = ils_pkg::ALL_ONES64;
            return r;
        end
        if (m.kind == ils_pkg::KIND_BEGIN) begin
            open_ts[s] = m.timestamp;
            open_flag[s] = 1'b1;
            r.status = ils_pkg::ST_BEGIN;
        end else if (!open_flag[s]) begin
            r.status = ils_pkg::ST_NO_BEGIN;
        end else begin
            el = m.timestamp - open_ts[s];
            if (el < min_t[s]) min_t[s] = el;
            if (el > max_t[s]) max_t[s] = el;
            acc = {1'b0, sum_t[s]} + {1'b0, el};
            sum_t[s] = acc[64] ? ils_pkg::ALL_ONES64 : acc[63:0];
            if (cnt_t[s] != ils_pkg::ALL_ONES32) cnt_t[s]++;
            open_flag[s] = 1'b0;
            r.status = ils_pkg::ST_END;
        end
        r.slot = s[3:0];
        r.sample_count = cnt_t[s];
        r.min_ticks = min_t[s];
        r.max_ticks = max_t[s];
        r.total_ticks = sum_t[s];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                stats_q.push_back(predict_stats(i_item));
                void'(marks_q.pop_front());
            end
            if ((!i_start || !o_busy) && marks_q.size() != 0
                    && $urandom_range(99) >= send_idle) begin
                i_start <= 1'b1;
                i_item <= marks_q[0];
            end else if (!i_start || !o_busy) begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (stats_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", o_result);
            end else begin
                if (o_result !== stats_q[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h actual %h", stats_q[0], o_result);
                end
                void'(stats_q.pop_front());
            end
        end
    end

    task automatic add_mark(logic kind, logic [31:0] key, logic [63:0] ts);
        ils_pkg::t_in m;
        m.kind = kind;
        m.event_key = key;
        m.timestamp = ts;
        marks_q.push_back(m);
    endtask

    task automatic wait_drain();
        while (marks_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] t0;
        for (int i = 0; i < NSLOT; i++) begin
            open_flag[i] = 1'b0;
            min_t[i] = ils_pkg::ALL_ONES64;
            max_t[i] = '0;
            sum_t[i] = '0;
            cnt_t[i] = '0;
            key_tab[i] = '0;
        end
        keys_used = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: new key on end, extremes, wrap, repeated begin, saturation of total, full table
        add_mark(ils_pkg::KIND_END, 32'hFFFF_FFFF, ils_pkg::ALL_ONES64);
        add_mark(ils_pkg::KIND_BEGIN, 32'hFFFF_FFFF, ils_pkg::ALL_ONES64);
        add_mark(ils_pkg::KIND_END, 32'hFFFF_FFFF, 64'd5);
        add_mark(ils_pkg::KIND_END, 32'hFFFF_FFFF, 64'd5);
        add_mark(ils_pkg::KIND_BEGIN, 32'h0, 64'd100);
        add_mark(ils_pkg::KIND_BEGIN, 32'h0, 64'd0);
        add_mark(ils_pkg::KIND_END, 32'h0, ils_pkg::ALL_ONES64);
        add_mark(ils_pkg::KIND_BEGIN, 32'h0, 64'd0);
        add_mark(ils_pkg::KIND_END, 32'h0, 64'h8000_0000_0000_0000);
        add_mark(ils_pkg::KIND_BEGIN, 32'h0, 64'd7);
        add_mark(ils_pkg::KIND_END, 32'h0, 64'd7);
        for (int k = 2; k < NSLOT; k++)
            add_mark(ils_pkg::KIND_BEGIN, 32'h1000 + 32'(k), rand64());
        add_mark(ils_pkg::KIND_BEGIN, 32'hDEAD_BEEF, 64'd1);
        add_mark(ils_pkg::KIND_END, 32'hDEAD_BEEF, 64'd2);
        for (int k = 2; k < NSLOT; k++) keys_pool[k] = 32'h1000 + 32'(k);
        keys_pool[0] = 32'hFFFF_FFFF;
        keys_pool[1] = 32'h0;

        // random: mostly begin/end pairs on known keys, some noise
        for (int n = 0; n < 2000; n++) begin
            int p;
            p = $urandom_range(99);
            t0 = rand64();
            if (p < 70) begin
                int k;
                k = $urandom_range(NSLOT - 1);
                add_mark(ils_pkg::KIND_BEGIN, keys_pool[k], t0);
                add_mark(ils_pkg::KIND_END, keys_pool[k],
                         t0 + (p < 50 ? 64'($urandom_range(1000)) : rand64()));
                n++;
            end else if (p < 90) begin
                add_mark(1'($urandom_range(1)), keys_pool[$urandom_range(NSLOT - 1)], t0);
            end else begin
                add_mark(1'($urandom_range(1)), $urandom, t0);
            end
            if (n >= 700 && send_idle == 15) begin
                wait_drain();
                send_idle = 55;
            end else if (n >= 1400 && send_idle == 55) begin
                wait_drain();
                send_idle = 0;
            end
        end
        wait_drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (stats_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
